// File: rtl/tcsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tcsq_pkg;

    // Default field widths
    localparam int COORD_BITS_DEF = 12;
    localparam int TIME_BITS_DEF  = 48;
    localparam int COUNT_BITS_DEF = 16;

    // Configuration register widths, index and reset values
    localparam int MIN_CONTACT_BITS = 16;
    localparam int RELEASE_BITS     = 4;
    localparam int CFG_DATA_BITS    = 16;
    localparam int CFG_INDEX_BITS   = 1;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_CONTACT = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RELEASE     = 1'd1;

    localparam logic [MIN_CONTACT_BITS-1:0] MIN_CONTACT_RST = 16'd15;
    localparam logic [RELEASE_BITS-1:0]     RELEASE_RST     = 4'd5;

    // Sample status codes
    localparam int STATUS_BITS = 2;
    localparam logic [STATUS_BITS-1:0] ST_CONTACT    = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NO_CONTACT = 2'd1;

    // Event codes
    localparam int EVENT_BITS = 3;
    localparam logic [EVENT_BITS-1:0] EV_IDLE          = 3'd0;
    localparam logic [EVENT_BITS-1:0] EV_BEGIN         = 3'd1;
    localparam logic [EVENT_BITS-1:0] EV_CONTACT       = 3'd2;
    localparam logic [EVENT_BITS-1:0] EV_FIRST_RELEASE = 3'd3;
    localparam logic [EVENT_BITS-1:0] EV_RELEASING     = 3'd4;
    localparam logic [EVENT_BITS-1:0] EV_TOO_SHORT     = 3'd5;
    localparam logic [EVENT_BITS-1:0] EV_SUMMARY       = 3'd6;
    localparam logic [EVENT_BITS-1:0] EV_ERROR         = 3'd7;

endpackage

`default_nettype wire

// File: rtl/touch_contact_session_qualifier.sv
// Path: an accepted input beat reaches its result beat through the input register,
//   then the session update into the result register.
// Throughput: one sample per cycle while i_out_stall does not hold the result register.
// Reset: synchronous, active low; clears the session, restores the register defaults
//   (15 contact samples, 5 release samples) and empties both pipeline registers.
`timescale 1ns / 1ps
`default_nettype none

module touch_contact_session_qualifier #(
    parameter int COORD_BITS = tcsq_pkg::COORD_BITS_DEF,
    parameter int TIME_BITS  = tcsq_pkg::TIME_BITS_DEF,
    parameter int COUNT_BITS = tcsq_pkg::COUNT_BITS_DEF
) (
    input  wire                                      i_clk,
    input  wire                                      i_rst_n,

    // configuration write port
    input  wire                                      i_cfg_wr_en,
    input  wire  [tcsq_pkg::CFG_INDEX_BITS-1:0]      i_cfg_index,
    input  wire  [tcsq_pkg::CFG_DATA_BITS-1:0]       i_cfg_data,

    // sample input channel
    input  wire                                      i_in_valid,
    output logic                                     o_in_stall,
    input  wire  [tcsq_pkg::STATUS_BITS-1:0]         i_sample_status,
    input  wire                                      i_contact_flag,
    input  wire  [COORD_BITS-1:0]                    i_raw_x,
    input  wire  [COORD_BITS-1:0]                    i_raw_y,
    input  wire  [COORD_BITS-1:0]                    i_pressure,
    input  wire  [TIME_BITS-1:0]                     i_time_us,

    // result output channel
    output logic                                     o_out_valid,
    input  wire                                      i_out_stall,
    output logic [tcsq_pkg::EVENT_BITS-1:0]          o_event_res,
    output logic [COUNT_BITS-1:0]                    o_count,
    output logic [COORD_BITS-1:0]                    o_x_low,
    output logic [COORD_BITS-1:0]                    o_x_high,
    output logic [COORD_BITS-1:0]                    o_y_low,
    output logic [COORD_BITS-1:0]                    o_y_high,
    output logic [COORD_BITS-1:0]                    o_pressure_low,
    output logic [COORD_BITS-1:0]                    o_pressure_high,
    output logic [TIME_BITS-1:0]                     o_first_time,
    output logic [TIME_BITS-1:0]                     o_last_time
);

    localparam int MIN_BITS = tcsq_pkg::MIN_CONTACT_BITS;
    localparam int REL_BITS = tcsq_pkg::RELEASE_BITS;
    // common width for the count vs. threshold compare
    localparam int CMP_BITS = (COUNT_BITS > MIN_BITS) ? COUNT_BITS : MIN_BITS;

    localparam logic [COORD_BITS-1:0] COORD_ONES = {COORD_BITS{1'b1}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [MIN_BITS-1:0] r_min_contact;
    logic [REL_BITS-1:0] r_release_samples;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_contact     <= tcsq_pkg::MIN_CONTACT_RST;
            r_release_samples <= tcsq_pkg::RELEASE_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                tcsq_pkg::CFG_MIN_CONTACT: begin
                    r_min_contact <= i_cfg_data[MIN_BITS-1:0];
                end
                tcsq_pkg::CFG_RELEASE: begin
                    r_release_samples <= i_cfg_data[REL_BITS-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // handshake: input register feeds the session update, which writes
    // the result register. The input register can take a beat while a
    // result is held stalled at the output.
    // ------------------------------------------------------------------
    logic w_advance;   // result register can be loaded this cycle
    logic w_process;   // the held sample is consumed this cycle
    logic w_in_accept;

    logic r_out_valid_q;

    logic                            r_in_valid;
    logic [tcsq_pkg::STATUS_BITS-1:0] r_in_status;
    logic                            r_in_flag;
    logic [COORD_BITS-1:0]           r_in_x;
    logic [COORD_BITS-1:0]           r_in_y;
    logic [COORD_BITS-1:0]           r_in_p;
    logic [TIME_BITS-1:0]            r_in_time;

    assign w_advance   = !r_out_valid_q || !i_out_stall;
    assign w_process   = r_in_valid && w_advance;
    assign o_in_stall  = r_in_valid && !w_advance;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_process) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_status <= i_sample_status;
            r_in_flag   <= i_contact_flag;
            r_in_x      <= i_raw_x;
            r_in_y      <= i_raw_y;
            r_in_p      <= i_pressure;
            r_in_time   <= i_time_us;
        end
    end

    // ------------------------------------------------------------------
    // session state; outside a session the statistics sit at their
    // cleared values, so a new session starts from the current registers
    // ------------------------------------------------------------------
    logic                  r_in_session;
    logic [REL_BITS-1:0]   r_release_run;
    logic                  r_release_reported;
    logic [COUNT_BITS-1:0] r_count;
    logic [COORD_BITS-1:0] r_x_min;
    logic [COORD_BITS-1:0] r_x_max;
    logic [COORD_BITS-1:0] r_y_min;
    logic [COORD_BITS-1:0] r_y_max;
    logic [COORD_BITS-1:0] r_p_min;
    logic [COORD_BITS-1:0] r_p_max;
    logic [TIME_BITS-1:0]  r_first_time;
    logic [TIME_BITS-1:0]  r_last_time;

    // next session control
    logic                  n_in_session;
    logic [REL_BITS-1:0]   n_release_run;
    logic                  n_release_reported;

    // statistics as reported with this beat
    logic [tcsq_pkg::EVENT_BITS-1:0] w_event;
    logic [COUNT_BITS-1:0] w_count;
    logic [COORD_BITS-1:0] w_x_min;
    logic [COORD_BITS-1:0] w_x_max;
    logic [COORD_BITS-1:0] w_y_min;
    logic [COORD_BITS-1:0] w_y_max;
    logic [COORD_BITS-1:0] w_p_min;
    logic [COORD_BITS-1:0] w_p_max;
    logic [TIME_BITS-1:0]  w_first_time;
    logic [TIME_BITS-1:0]  w_last_time;
    logic                  w_clear;     // session ends or errors out
    logic [REL_BITS-1:0]   w_run_inc;

    always_comb begin
        w_event            = tcsq_pkg::EV_IDLE;
        w_count            = r_count;
        w_x_min            = r_x_min;
        w_x_max            = r_x_max;
        w_y_min            = r_y_min;
        w_y_max            = r_y_max;
        w_p_min            = r_p_min;
        w_p_max            = r_p_max;
        w_first_time       = r_first_time;
        w_last_time        = r_last_time;
        w_clear            = 1'b0;
        n_in_session       = r_in_session;
        n_release_run      = r_release_run;
        n_release_reported = r_release_reported;
        w_run_inc          = (r_release_run < r_release_samples) ?
                             r_release_run + 1'b1 : r_release_run;

        if (r_in_status == tcsq_pkg::ST_CONTACT && r_in_flag) begin
            w_event       = r_in_session ? tcsq_pkg::EV_CONTACT : tcsq_pkg::EV_BEGIN;
            n_in_session  = 1'b1;
            n_release_run = '0;
            if (r_count == '0) begin
                w_first_time = r_in_time;
            end
            if (!(&r_count)) begin
                w_count = r_count + 1'b1;
            end
            w_last_time = r_in_time;
            if (r_in_x < r_x_min) w_x_min = r_in_x;
            if (r_in_x > r_x_max) w_x_max = r_in_x;
            if (r_in_y < r_y_min) w_y_min = r_in_y;
            if (r_in_y > r_y_max) w_y_max = r_in_y;
            if (r_in_p < r_p_min) w_p_min = r_in_p;
            if (r_in_p > r_p_max) w_p_max = r_in_p;
        end else if (r_in_status == tcsq_pkg::ST_NO_CONTACT) begin
            if (r_in_session) begin
                // first release is reported once per session
                w_event = r_release_reported ? tcsq_pkg::EV_RELEASING
                                             : tcsq_pkg::EV_FIRST_RELEASE;
                n_release_reported = 1'b1;
                n_release_run      = w_run_inc;
                if (w_run_inc >= r_release_samples) begin
                    // session over: report with the stats before clearing
                    w_clear = 1'b1;
                    w_event = (CMP_BITS'(r_count) >= CMP_BITS'(r_min_contact)) ?
                              tcsq_pkg::EV_SUMMARY : tcsq_pkg::EV_TOO_SHORT;
                end
            end
        end else begin
            // contact status without flag, controller error, reserved code
            w_clear      = 1'b1;
            w_event      = tcsq_pkg::EV_ERROR;
            w_count      = '0;
            w_x_min      = COORD_ONES;
            w_x_max      = '0;
            w_y_min      = COORD_ONES;
            w_y_max      = '0;
            w_p_min      = COORD_ONES;
            w_p_max      = '0;
            w_first_time = '0;
            w_last_time  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_process && w_clear)) begin
            r_in_session       <= 1'b0;
            r_release_run      <= '0;
            r_release_reported <= 1'b0;
            r_count            <= '0;
            r_x_min            <= COORD_ONES;
            r_x_max            <= '0;
            r_y_min            <= COORD_ONES;
            r_y_max            <= '0;
            r_p_min            <= COORD_ONES;
            r_p_max            <= '0;
            r_first_time       <= '0;
            r_last_time        <= '0;
        end else if (w_process) begin
            r_in_session       <= n_in_session;
            r_release_run      <= n_release_run;
            r_release_reported <= n_release_reported;
            r_count            <= w_count;
            r_x_min            <= w_x_min;
            r_x_max            <= w_x_max;
            r_y_min            <= w_y_min;
            r_y_max            <= w_y_max;
            r_p_min            <= w_p_min;
            r_p_max            <= w_p_max;
            r_first_time       <= w_first_time;
            r_last_time        <= w_last_time;
        end
    end

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid_q <= 1'b0;
        end else if (w_advance) begin
            r_out_valid_q <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_process) begin
            o_event_res     <= w_event;
            o_count         <= w_count;
            o_x_low         <= w_x_min;
            o_x_high        <= w_x_max;
            o_y_low         <= w_y_min;
            o_y_high        <= w_y_max;
            o_pressure_low  <= w_p_min;
            o_pressure_high <= w_p_max;
            o_first_time    <= w_first_time;
            o_last_time     <= w_last_time;
        end
    end

    assign o_out_valid = r_out_valid_q;

endmodule

`default_nettype wire

// File: bench/tb.sv
`timescale 1ns / 1ps

// Bench for touch_contact_session_qualifier.
// Every accepted sample beat runs through a local session tracker that
// predicts the one result beat it causes. Result beats are checked in order,
// field by field.
module tb;
    import tcsq_pkg::*;

    localparam int COORD_W = COORD_BITS_DEF;
    localparam int TIME_W  = TIME_BITS_DEF;
    localparam int COUNT_W = COUNT_BITS_DEF;

    localparam logic [COORD_W-1:0] COORD_MAX = '1;
    localparam logic [TIME_W-1:0]  TIME_MAX  = '1;

    // status codes the package leaves unnamed; both count as errors
    localparam logic [STATUS_BITS-1:0] ST_CTRL_ERROR = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_UNDEFINED  = 2'd3;

    localparam int HOLD_CYCLES = 64;     // one long receiver hold-off
    localparam int MAX_PRINTS  = 40;     // mismatch lines printed, all are counted

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        logic                   flag;
        logic [COORD_W-1:0]     x;
        logic [COORD_W-1:0]     y;
        logic [COORD_W-1:0]     p;
        logic [TIME_W-1:0]      t;
    } touch_sample_t;

    typedef struct packed {
        logic [EVENT_BITS-1:0] ev;
        logic [COUNT_W-1:0]    count;
        logic [COORD_W-1:0]    x_lo;
        logic [COORD_W-1:0]    x_hi;
        logic [COORD_W-1:0]    y_lo;
        logic [COORD_W-1:0]    y_hi;
        logic [COORD_W-1:0]    p_lo;
        logic [COORD_W-1:0]    p_hi;
        logic [TIME_W-1:0]     t_first;
        logic [TIME_W-1:0]     t_last;
    } session_result_t;

    // one line of the directed script; want is only used when typed is set
    typedef struct {
        touch_sample_t   smp;
        bit              typed;
        session_result_t want;
    } script_row_t;

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic clk;
    logic rst_n;

    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    logic                   in_valid;
    logic                   in_stall;
    logic [STATUS_BITS-1:0] in_status;
    logic                   in_flag;
    logic [COORD_W-1:0]     in_x;
    logic [COORD_W-1:0]     in_y;
    logic [COORD_W-1:0]     in_p;
    logic [TIME_W-1:0]      in_t;

    logic                  out_valid;
    logic                  out_stall;
    logic [EVENT_BITS-1:0] out_event;
    logic [COUNT_W-1:0]    out_count;
    logic [COORD_W-1:0]    out_x_low;
    logic [COORD_W-1:0]    out_x_high;
    logic [COORD_W-1:0]    out_y_low;
    logic [COORD_W-1:0]    out_y_high;
    logic [COORD_W-1:0]    out_p_low;
    logic [COORD_W-1:0]    out_p_high;
    logic [TIME_W-1:0]     out_first_time;
    logic [TIME_W-1:0]     out_last_time;

    touch_contact_session_qualifier uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_wr_en     (cfg_wr_en),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data),
        .i_in_valid      (in_valid),
        .o_in_stall      (in_stall),
        .i_sample_status (in_status),
        .i_contact_flag  (in_flag),
        .i_raw_x         (in_x),
        .i_raw_y         (in_y),
        .i_pressure      (in_p),
        .i_time_us       (in_t),
        .o_out_valid     (out_valid),
        .i_out_stall     (out_stall),
        .o_event_res     (out_event),
        .o_count         (out_count),
        .o_x_low         (out_x_low),
        .o_x_high        (out_x_high),
        .o_y_low         (out_y_low),
        .o_y_high        (out_y_high),
        .o_pressure_low  (out_p_low),
        .o_pressure_high (out_p_high),
        .o_first_time    (out_first_time),
        .o_last_time     (out_last_time)
    );

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    session_result_t pending_results[$];   // predictions, oldest first

    int  send_idle_pct;
    int  recv_idle_pct;
    int  beats_in;
    int  beats_out;
    int  mismatches;
    int  settings_used;
    int  ev_seen[8];
    bit  long_hold_done;
    logic [TIME_W-1:0] t_now;              // running sample clock for sessions

    // session tracker: register copies and session state
    logic [MIN_CONTACT_BITS-1:0] need_contacts;
    logic [RELEASE_BITS-1:0]     rel_needed;
    logic                        sess_open;
    logic [RELEASE_BITS-1:0]     rel_run;
    logic                        rel_reported;
    session_result_t             sess;     // ev field unused, stats only

    // 2 ns clock
    initial clk = 1'b0;
    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Result constructors
    // ------------------------------------------------------------------
    function automatic session_result_t blank(input logic [EVENT_BITS-1:0] ev);
        session_result_t r;
        r      = '0;
        r.ev   = ev;
        r.x_lo = COORD_MAX;
        r.y_lo = COORD_MAX;
        r.p_lo = COORD_MAX;
        return r;
    endfunction

    function automatic session_result_t result_of(
        input logic [EVENT_BITS-1:0] ev,
        input logic [COUNT_W-1:0]    count,
        input logic [COORD_W-1:0]    xl, xh, yl, yh, pl, ph,
        input logic [TIME_W-1:0]     tf, tl
    );
        return '{ev, count, xl, xh, yl, yh, pl, ph, tf, tl};
    endfunction

    function automatic touch_sample_t sample_of(
        input logic [STATUS_BITS-1:0] status,
        input logic                   flag,
        input logic [COORD_W-1:0]     x, y, p,
        input logic [TIME_W-1:0]      t
    );
        return '{status, flag, x, y, p, t};
    endfunction

    // ------------------------------------------------------------------
    // Session tracker
    // ------------------------------------------------------------------
    function automatic void drop_session();
        sess_open    = 1'b0;
        rel_run      = '0;
        rel_reported = 1'b0;
        sess         = blank(EV_IDLE);
    endfunction

    // Advances the tracker by one sample and returns the result beat it causes.
    function automatic session_result_t track_session(input touch_sample_t s);
        session_result_t       r;
        logic [EVENT_BITS-1:0] ev_now;
        if (s.status == ST_CONTACT && s.flag) begin
            ev_now = EV_CONTACT;
            if (!sess_open) begin
                drop_session();
                sess_open = 1'b1;
                ev_now    = EV_BEGIN;
            end
            rel_run = '0;
            if (sess.count == '0)
                sess.t_first = s.t;
            if (sess.count != '1)
                sess.count = sess.count + 1'b1;
            sess.t_last = s.t;
            if (s.x < sess.x_lo) sess.x_lo = s.x;
            if (s.x > sess.x_hi) sess.x_hi = s.x;
            if (s.y < sess.y_lo) sess.y_lo = s.y;
            if (s.y > sess.y_hi) sess.y_hi = s.y;
            if (s.p < sess.p_lo) sess.p_lo = s.p;
            if (s.p > sess.p_hi) sess.p_hi = s.p;
            r    = sess;
            r.ev = ev_now;
        end else if (s.status == ST_NO_CONTACT && sess_open) begin
            // first release is reported once per session, even after renewed contact
            ev_now       = rel_reported ? EV_RELEASING : EV_FIRST_RELEASE;
            rel_reported = 1'b1;
            if (rel_run < rel_needed)
                rel_run = rel_run + 1'b1;
            r = sess;
            if (rel_run >= rel_needed) begin
                // stats go out as they stood, then the session is gone
                ev_now = (COUNT_W'(sess.count) >= COUNT_W'(need_contacts)) ?
                         EV_SUMMARY : EV_TOO_SHORT;
                drop_session();
            end
            r.ev = ev_now;
        end else if (s.status == ST_NO_CONTACT) begin
            r    = sess;
            r.ev = EV_IDLE;
        end else begin
            // controller error, undefined status, contact without the flag
            drop_session();
            r    = sess;
            r.ev = EV_ERROR;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (mismatches < MAX_PRINTS)
            $display("%0t ns: result beat %0d: %s got %0h want %0h",
                     $time, beats_out, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk) begin : check_results
        session_result_t got;
        session_result_t want;
        if (rst_n && out_valid && !out_stall) begin
            got = '{out_event, out_count, out_x_low, out_x_high, out_y_low, out_y_high,
                    out_p_low, out_p_high, out_first_time, out_last_time};
            beats_out++;
            ev_seen[got.ev]++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result beat, event_res", 64'(got.ev), 64'd0);
            end else begin
                want = pending_results.pop_front();
                if (got.ev !== want.ev)
                    report_mismatch("event_res", 64'(got.ev), 64'(want.ev));
                if (got.count !== want.count)
                    report_mismatch("count", 64'(got.count), 64'(want.count));
                if (got.x_lo !== want.x_lo)
                    report_mismatch("x_low", 64'(got.x_lo), 64'(want.x_lo));
                if (got.x_hi !== want.x_hi)
                    report_mismatch("x_high", 64'(got.x_hi), 64'(want.x_hi));
                if (got.y_lo !== want.y_lo)
                    report_mismatch("y_low", 64'(got.y_lo), 64'(want.y_lo));
                if (got.y_hi !== want.y_hi)
                    report_mismatch("y_high", 64'(got.y_hi), 64'(want.y_hi));
                if (got.p_lo !== want.p_lo)
                    report_mismatch("pressure_low", 64'(got.p_lo), 64'(want.p_lo));
                if (got.p_hi !== want.p_hi)
                    report_mismatch("pressure_high", 64'(got.p_hi), 64'(want.p_hi));
                if (got.t_first !== want.t_first)
                    report_mismatch("first_time", 64'(got.t_first), 64'(want.t_first));
                if (got.t_last !== want.t_last)
                    report_mismatch("last_time", 64'(got.t_last), 64'(want.t_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Result side: random stall, plus one long hold-off once traffic runs.
    // The hold is counted here so the sender keeps offering beats and the
    // block backs up into its input.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (!long_hold_done && beats_in >= 40) begin
                long_hold_done = 1'b1;
                hold_left      = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // ------------------------------------------------------------------
    // Sample side
    // ------------------------------------------------------------------
    // Offers one beat (after an optional random gap), holds it until taken,
    // then records the prediction.
    task automatic push_sample(input touch_sample_t s);
        if (send_idle_pct != 0) begin
            while ($urandom_range(99) < send_idle_pct) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid  <= 1'b1;
        in_status <= s.status;
        in_flag   <= s.flag;
        in_x      <= s.x;
        in_y      <= s.y;
        in_p      <= s.p;
        in_t      <= s.t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        beats_in++;
        pending_results.push_back(track_session(s));
    endtask

    // Stops offering beats and waits out every outstanding result, plus the
    // two-stage pipe, so the block is idle.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_registers(input logic [MIN_CONTACT_BITS-1:0] min_c,
                                 input logic [RELEASE_BITS-1:0] rel);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_MIN_CONTACT;
        cfg_data  <= CFG_DATA_BITS'(min_c);
        @(posedge clk);
        cfg_index <= CFG_RELEASE;
        cfg_data  <= CFG_DATA_BITS'(rel);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        need_contacts = min_c;
        rel_needed    = rel;
        settings_used++;
    endtask

    // Sample on the running session clock with random readings.
    function automatic touch_sample_t touch_at(input logic [STATUS_BITS-1:0] status,
                                               input logic flag);
        touch_sample_t s;
        s     = sample_of(status, flag, COORD_W'($urandom), COORD_W'($urandom),
                          COORD_W'($urandom), t_now);
        t_now = t_now + TIME_W'($urandom_range(1, 5000));
        return s;
    endfunction

    function automatic touch_sample_t noise_sample();
        return sample_of(STATUS_BITS'($urandom), 1'($urandom), COORD_W'($urandom),
                         COORD_W'($urandom), COORD_W'($urandom),
                         {16'($urandom), $urandom});
    endfunction

    // A well-formed press: contacts, sometimes a partial release and renewed
    // contact, then a release run long enough to end it (a few spare no-contact
    // beats land as idle). Now and then the session is cut by an error instead.
    task automatic play_session();
        int rounds;
        int contacts;
        int partial;
        int cut;
        t_now  = {16'($urandom), $urandom};
        rounds = ($urandom_range(3) == 0) ? 2 : 1;
        for (int r = 0; r < rounds; r++) begin
            if (need_contacts <= 24)
                contacts = $urandom_range(1, int'(need_contacts) + 3);
            else
                contacts = $urandom_range(1, 24);
            repeat (contacts) push_sample(touch_at(ST_CONTACT, 1'b1));
            if (r < rounds - 1) begin
                partial = (rel_needed > 1) ? $urandom_range(1, int'(rel_needed) - 1) : 0;
                repeat (partial) push_sample(touch_at(ST_NO_CONTACT, 1'($urandom)));
            end
        end
        if ($urandom_range(9) == 0) begin
            cut = $urandom_range(2);
            if (cut == 0)
                push_sample(touch_at(ST_CTRL_ERROR, 1'($urandom)));
            else if (cut == 1)
                push_sample(touch_at(ST_UNDEFINED, 1'($urandom)));
            else
                push_sample(touch_at(ST_CONTACT, 1'b0));
        end else begin
            repeat (int'(rel_needed) + $urandom_range(2))
                push_sample(touch_at(ST_NO_CONTACT, 1'($urandom)));
        end
    endtask

    // Mostly sessions; the rest is raw noise and stray no-contact beats.
    task automatic random_traffic(input int quota);
        int first;
        int pick;
        first = beats_in;
        while (beats_in - first < quota) begin
            pick = $urandom_range(99);
            if (pick < 15)
                push_sample(noise_sample());
            else if (pick < 22)
                push_sample(touch_at(ST_NO_CONTACT, 1'($urandom)));
            else
                play_session();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        script_row_t script[$];
        // drive every input before the first edge
        rst_n          = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_MIN_CONTACT;
        cfg_data       = '0;
        in_valid       = 1'b0;
        in_status      = ST_NO_CONTACT;
        in_flag        = 1'b0;
        in_x           = '0;
        in_y           = '0;
        in_p           = '0;
        in_t           = '0;
        beats_in       = 0;
        beats_out      = 0;
        mismatches     = 0;
        settings_used  = 1;
        long_hold_done = 1'b0;
        t_now          = '0;
        foreach (ev_seen[i]) ev_seen[i] = 0;
        need_contacts  = MIN_CONTACT_RST;
        rel_needed     = RELEASE_RST;
        drop_session();

        // sender idles 32%, receiver 82%
        send_idle_pct = 32;
        recv_idle_pct = 82;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed script at the reset settings (15 contacts, 5 releases).
        // Idle and error beats carry the cleared stats.
        script.push_back('{sample_of(ST_NO_CONTACT, 1'b0, '0, '0, '0, '0),
                           1'b1, blank(EV_IDLE)});
        script.push_back('{sample_of(ST_NO_CONTACT, 1'b1, COORD_MAX, COORD_MAX,
                                     COORD_MAX, TIME_MAX), 1'b1, blank(EV_IDLE)});
        script.push_back('{sample_of(ST_CTRL_ERROR, 1'b1, 12'h5a5, 12'ha5a, 12'h0ff,
                                     48'h1), 1'b1, blank(EV_ERROR)});
        script.push_back('{sample_of(ST_UNDEFINED, 1'b1, COORD_MAX, COORD_MAX,
                                     COORD_MAX, TIME_MAX), 1'b1, blank(EV_ERROR)});
        // contact status without the flag
        script.push_back('{sample_of(ST_CONTACT, 1'b0, 12'h123, 12'h456, 12'h789,
                                     48'h2), 1'b1, blank(EV_ERROR)});
        // opposite extremes on consecutive contacts, times at zero and all ones
        script.push_back('{sample_of(ST_CONTACT, 1'b1, '0, COORD_MAX, '0, '0), 1'b1,
                           result_of(EV_BEGIN, 16'd1, '0, '0, COORD_MAX, COORD_MAX,
                                     '0, '0, '0, '0)});
        script.push_back('{sample_of(ST_CONTACT, 1'b1, COORD_MAX, '0, COORD_MAX,
                                     TIME_MAX), 1'b1,
                           result_of(EV_CONTACT, 16'd2, '0, COORD_MAX, '0, COORD_MAX,
                                     '0, COORD_MAX, '0, TIME_MAX)});
        // first release, releasing, then renewed contact restarts the run
        script.push_back('{sample_of(ST_NO_CONTACT, 1'b0, '0, '0, '0, 48'h3), 1'b0,
                           blank(EV_IDLE)});
        script.push_back('{sample_of(ST_NO_CONTACT, 1'b1, '0, '0, '0, 48'h4), 1'b0,
                           blank(EV_IDLE)});
        script.push_back('{sample_of(ST_CONTACT, 1'b1, 12'h800, 12'h800, 12'h800,
                                     48'h10), 1'b0, blank(EV_IDLE)});
        // full release run: no new first release, fifth beat ends it too short
        repeat (5)
            script.push_back('{sample_of(ST_NO_CONTACT, 1'b0, 12'h111, 12'h222,
                                         12'h333, 48'h11), 1'b0, blank(EV_IDLE)});
        script.push_back('{sample_of(ST_NO_CONTACT, 1'b0, '0, '0, '0, 48'h12), 1'b1,
                           blank(EV_IDLE)});
        // error in the middle of a session, both forms
        script.push_back('{sample_of(ST_CONTACT, 1'b1, 12'h0a5, 12'h5a0, 12'h3c3,
                                     48'h20), 1'b0, blank(EV_IDLE)});
        script.push_back('{sample_of(ST_CTRL_ERROR, 1'b0, '0, '0, '0, 48'h21), 1'b1,
                           blank(EV_ERROR)});
        script.push_back('{sample_of(ST_CONTACT, 1'b1, 12'h700, 12'h070, 12'h007,
                                     48'h22), 1'b0, blank(EV_IDLE)});
        script.push_back('{sample_of(ST_CONTACT, 1'b0, 12'h700, 12'h070, 12'h007,
                                     48'h23), 1'b1, blank(EV_ERROR)});

        foreach (script[i]) begin
            push_sample(script[i].smp);
            // typed rows replace the prediction before its result beat comes out
            if (script[i].typed)
                pending_results[$] = script[i].want;
        end

        random_traffic(300);

        // one contact and one release beat suffice: first release ends it
        set_registers(16'd1, 4'd1);
        random_traffic(300);

        // other way round on idling
        send_idle_pct = 82;
        recv_idle_pct = 32;

        // zero on both: a session that reaches a release ends at the first one, as a summary
        set_registers(16'd0, 4'd0);
        random_traffic(150);

        // top of both ranges: sessions here end too short
        set_registers(16'hffff, 4'hf);
        random_traffic(300);

        // no idling from here on
        send_idle_pct = 0;
        recv_idle_pct = 0;

        set_registers(16'd3, 4'd2);
        random_traffic(300);

        set_registers(16'd8, 4'd4);
        random_traffic(200);

        drain();
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 64'(pending_results.size()), 64'd0);

        $display("Run: %0d sample beats in, %0d result beats out, %0d register settings",
                 beats_in, beats_out, settings_used);
        $display("Events: idle %0d begin %0d contact %0d first-rel %0d releasing %0d %s",
                 ev_seen[EV_IDLE], ev_seen[EV_BEGIN], ev_seen[EV_CONTACT],
                 ev_seen[EV_FIRST_RELEASE], ev_seen[EV_RELEASING],
                 $sformatf("too-short %0d summary %0d error %0d", ev_seen[EV_TOO_SHORT],
                           ev_seen[EV_SUMMARY], ev_seen[EV_ERROR]));
        if (mismatches == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog, far above the slowest legal run.
    initial begin : watchdog
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
